### src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Word and count widths, command and status codes, cell control.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [IDX_W-1:0] index_t;
    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT,
        CELL_APPEND
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        count_t   count;
    } cell_ctrl_t;

endpackage

### src/dq_if.sv
// ----------------------------------------------------------------------------
// dq_cmd_if / dq_rsp_if: valid-ready channels of the double-ended queue
// Command channel into the queue and response channel out of it.
// ----------------------------------------------------------------------------
interface dq_cmd_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface dq_rsp_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] removed_value;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output removed_value, output status,
                    output fill_count, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input fill_count, output ready);
endinterface

### src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// A row of cells holds the entries in order, front in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries a transaction with command (push front, push back, pop
//   front, pop back) and push_value. Every transaction yields exactly one
//   transaction on rsp: removed_value, status and fill_count after it.
//   A pop on an empty queue answers -1 with status empty; a push on a full
//   queue is dropped and answered with status full; pushes answer 0.
//   The response is registered and appears in the cycle after the
//   command is accepted. Throughput: one command per cycle while rsp is
//   not stalled; the cell row shifts or appends as the command is taken,
//   and the response register is the only stage.
//   While rsp is stalled the response register holds and cmd.ready stays
//   low; a new command is taken in the same cycle the held response leaves.
//   Reset empties the queue at once; stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
(
    input  logic       clk,
    input  logic       rst_n,
    dq_cmd_if.sink     cmd,
    dq_rsp_if.source   rsp
);
    import dq_pkg::*;

    count_t     count_reg;
    count_t     count_next;
    logic       rsp_valid_reg;
    word_t      removed_value_reg;
    word_t      removed_value_next;
    status_t    status_reg;
    status_t    status_next;
    cell_op_t   op;
    cell_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       empty;
    word_t      cell_word [CAPACITY];
    word_t      cell_tail [CAPACITY];
    word_t      back_word;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_word = back_word | cell_tail[i];
        end
    end

    always_comb
    begin
        op                 = CELL_HOLD;
        count_next         = count_reg;
        removed_value_next = '0;
        status_next        = ST_OK;
        unique case (cmd_t'(cmd.command))
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op = (cmd_t'(cmd.command) == CMD_PUSH_FRONT) ? CELL_TAKE_PREV
                                                                 : CELL_APPEND;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next        = ST_EMPTY;
                    removed_value_next = '1;
                end
                else
                begin
                    if (cmd_t'(cmd.command) == CMD_POP_FRONT)
                    begin
                        op                 = CELL_TAKE_NEXT;
                        removed_value_next = cell_word[0];
                    end
                    else
                    begin
                        removed_value_next = back_word;
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase
        if (!accept)
        begin
            op         = CELL_HOLD;
            count_next = count_reg;
        end
    end

    assign ctrl.op    = op;
    assign ctrl.count = count_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t prev_w;
        word_t next_w;

        if (g == 0)
        begin : g_head
            assign prev_w = cmd.push_value;
        end
        else
        begin : g_mid
            assign prev_w = cell_word[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_body
            assign next_w = cell_word[g+1];
        end

        dq_cell u_cell
        (
            .clk        (clk),
            .cell_index (IDX_W'(g)),
            .ctrl       (ctrl),
            .prev_word  (prev_w),
            .next_word  (next_w),
            .push_word  (cmd.push_value),
            .word       (cell_word[g]),
            .tail_word  (cell_tail[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.ready)
            begin
                rsp_valid_reg <= cmd.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_value_reg <= removed_value_next;
            status_reg        <= status_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = removed_value_reg;
    assign rsp.status        = status_reg;
    assign rsp.fill_count    = FILL_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("accepted command without response");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && !cmd.command[1] |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the queue");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !empty && cmd.command[1] |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not shrink the queue");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg == ST_EMPTY |-> removed_value_reg == '1)
        else $error("empty pop without all-ones value");

endmodule

### src/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word; takes its neighbor's word on a shift or the pushed word
// when it is the first free cell; offers its word when it is the tail.
// ----------------------------------------------------------------------------
module dq_cell
(
    input  logic                clk,
    input  dq_pkg::index_t      cell_index,
    input  dq_pkg::cell_ctrl_t  ctrl,
    input  dq_pkg::word_t       prev_word,
    input  dq_pkg::word_t       next_word,
    input  dq_pkg::word_t       push_word,
    output dq_pkg::word_t       word,
    output dq_pkg::word_t       tail_word
);
    import dq_pkg::*;

    word_t  word_reg;
    word_t  word_next;
    count_t position;

    assign position = CNT_W'(cell_index);

    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.op)
            CELL_TAKE_PREV: word_next = prev_word;
            CELL_TAKE_NEXT: word_next = next_word;
            CELL_APPEND:
            begin
                if (position == ctrl.count)
                begin
                    word_next = push_word;
                end
            end
            default:        word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign tail_word = (position + CNT_W'(1) == ctrl.count) ? word_reg : '0;

endmodule
